@@ rtl/tird_pkg.sv @@
// Shared types and constants for the tape image record deframer.
package tird_pkg;

  localparam int unsigned LEN_W = 24;

  localparam logic [31:0] MARK_EOM      = 32'hFFFF_FFFF;
  localparam logic [31:0] MARK_GAP      = 32'hFFFF_FFFE;
  localparam logic [31:0] MARK_TAPEMARK = 32'h0000_0000;
  localparam logic [31:0] RSVD_MASK     = 32'h7F00_0000;

  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_START = 3'd1,
    EV_END   = 3'd2,
    EV_MARK  = 3'd3,
    EV_GAP   = 3'd4,
    EV_EOM   = 3'd5,
    EV_ERR   = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RESERVED = 3'd1,
    ERR_ZERO_LEN = 3'd2,
    ERR_TRAIL    = 3'd3,
    ERR_NO_EOM   = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_PAD   = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_t;

  typedef struct packed {
    logic             valid;
    event_t           kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             bad;
    logic             last;
    err_t             err;
  } result_t;

  typedef struct packed {
    logic   stopped;
    phase_t phase;
  } status_t;

endpackage

@@ rtl/tird_ifs.sv @@
// Valid/ready channel interfaces for tape bytes and deframer events.
interface tird_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tape_byte;
  logic       end_of_data;
  modport source (output valid, tape_byte, end_of_data, input ready);
  modport sink (input valid, tape_byte, end_of_data, output ready);
endinterface

interface tird_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  data_byte;
  logic [23:0] record_length;
  logic        record_had_errors;
  logic        last_in_record;
  logic [2:0]  error_code;
  modport source (output valid, event_kind, data_byte, record_length, record_had_errors,
                  last_in_record, error_code, input ready);
  modport sink (input valid, event_kind, data_byte, record_length, record_had_errors,
                last_in_record, error_code, output ready);
endinterface

@@ rtl/tird_core.sv @@
// Framing state and per-byte decode of markers, data and pad bytes.
module tird_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          tape_byte,
  input  logic                end_of_data,
  output tird_pkg::result_t   res,
  output tird_pkg::status_t   status
);

  tird_pkg::phase_t                phase, phase_next;
  logic                            stopped, stopped_next;
  logic [1:0]                      idx, idx_next;
  logic [23:0]                     acc, acc_next;
  logic [tird_pkg::LEN_W-1:0]      len, len_next;
  logic [tird_pkg::LEN_W-1:0]      rem, rem_next;
  logic [31:0]                     marker;
  logic [tird_pkg::LEN_W-1:0]      rem_dec;

  assign marker  = {tape_byte, acc};
  assign rem_dec = rem - tird_pkg::LEN_W'(1);

  always_comb begin
    phase_next   = phase;
    stopped_next = stopped;
    idx_next     = idx;
    acc_next     = acc;
    len_next     = len;
    rem_next     = rem;
    res          = '0;
    res.kind     = tird_pkg::EV_DATA;
    res.err      = tird_pkg::ERR_NONE;
    if (!stopped) begin
      if (end_of_data) begin
        stopped_next = 1'b1;
        res.valid    = 1'b1;
        res.kind     = tird_pkg::EV_ERR;
        res.err      = tird_pkg::ERR_NO_EOM;
      end else begin
        unique case (phase)
          tird_pkg::PH_LEAD, tird_pkg::PH_TRAIL: begin
            if (idx != 2'd3) begin
              acc_next[{idx, 3'b000} +: 8] = tape_byte;
              idx_next = idx + 2'd1;
            end else begin
              idx_next = 2'd0;
              acc_next = '0;
              res.valid = 1'b1;
              if (phase == tird_pkg::PH_TRAIL) begin
                phase_next = tird_pkg::PH_LEAD;
                if (marker[23:0] != len) begin
                  stopped_next = 1'b1;
                  res.kind     = tird_pkg::EV_ERR;
                  res.err      = tird_pkg::ERR_TRAIL;
                end else begin
                  res.kind = tird_pkg::EV_END;
                  res.len  = len;
                end
              end else begin
                priority if (marker == tird_pkg::MARK_EOM) begin
                  stopped_next = 1'b1;
                  res.kind     = tird_pkg::EV_EOM;
                end else if (marker == tird_pkg::MARK_GAP) begin
                  res.kind = tird_pkg::EV_GAP;
                end else if (marker == tird_pkg::MARK_TAPEMARK) begin
                  res.kind = tird_pkg::EV_MARK;
                end else if ((marker & tird_pkg::RSVD_MASK) != '0) begin
                  stopped_next = 1'b1;
                  res.kind     = tird_pkg::EV_ERR;
                  res.err      = tird_pkg::ERR_RESERVED;
                end else if (marker[23:0] == '0) begin
                  stopped_next = 1'b1;
                  res.kind     = tird_pkg::EV_ERR;
                  res.err      = tird_pkg::ERR_ZERO_LEN;
                end else begin
                  len_next   = marker[23:0];
                  rem_next   = marker[23:0];
                  phase_next = tird_pkg::PH_DATA;
                  res.kind   = tird_pkg::EV_START;
                  res.len    = marker[23:0];
                  res.bad    = marker[31];
                end
              end
            end
          end
          tird_pkg::PH_DATA: begin
            rem_next  = rem_dec;
            res.valid = 1'b1;
            res.data  = tape_byte;
            if (rem_dec == '0) begin
              phase_next = len[0] ? tird_pkg::PH_PAD : tird_pkg::PH_TRAIL;
              idx_next   = 2'd0;
              acc_next   = '0;
              res.last   = 1'b1;
            end
          end
          tird_pkg::PH_PAD: begin
            phase_next = tird_pkg::PH_TRAIL;
          end
          default: begin
            phase_next = tird_pkg::PH_LEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= tird_pkg::PH_LEAD;
      stopped <= 1'b0;
      idx     <= 2'd0;
      acc     <= '0;
    end else if (take) begin
      phase   <= phase_next;
      stopped <= stopped_next;
      idx     <= idx_next;
      acc     <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      len <= len_next;
      rem <= rem_next;
    end
  end

  assign status.stopped = stopped;
  assign status.phase   = phase;

endmodule

@@ rtl/tird_out_reg.sv @@
// Result register between the decode logic and the event channel.
module tird_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tird_pkg::result_t res_in,
  input  logic              sink_ready,
  output logic              room,
  output logic              valid,
  output tird_pkg::result_t held
);

  assign room = !valid || sink_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load && res_in.valid) begin
      valid <= 1'b1;
    end else if (sink_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_in.valid) begin
      held <= res_in;
    end
  end

endmodule

@@ rtl/tape_image_record_deframer_unit.sv @@
// Top level of the tape image record deframer.
//
//   channel  dir  contents
//   tape     in   tape_byte, end_of_data
//   events   out  event_kind, data_byte, record_length, record_had_errors,
//                 last_in_record, error_code
//
// One byte per cycle while tape.ready; results reach events the next cycle.
// The decode of a byte and the result register form the only stage.
// tape.ready is low only while a held result waits on events.ready.
// Synchronous reset returns to awaiting a leading marker.
module tape_image_record_deframer_unit (
  input  logic              clk,
  input  logic              rst,
  tird_in_if.sink           tape,
  tird_out_if.source        events
);

  tird_pkg::result_t res;
  tird_pkg::result_t held;
  tird_pkg::status_t status;
  logic              room;
  logic              take;

  assign take       = tape.valid && room;
  assign tape.ready = room;

  tird_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .tape_byte   (tape.tape_byte),
    .end_of_data (tape.end_of_data),
    .res         (res),
    .status      (status)
  );

  tird_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .res_in     (res),
    .sink_ready (events.ready),
    .room       (room),
    .valid      (events.valid),
    .held       (held)
  );

  assign events.event_kind        = held.kind;
  assign events.data_byte         = held.data;
  assign events.record_length     = held.len;
  assign events.record_had_errors = held.bad;
  assign events.last_in_record    = held.last;
  assign events.error_code        = held.err;

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    status.stopped |=> status.stopped)
    else $error("stopped flag cleared without reset");

  a_stop_on_final: assert property (@(posedge clk) disable iff (rst)
    (take && res.valid && (res.kind == tird_pkg::EV_EOM || res.kind == tird_pkg::EV_ERR))
    |=> status.stopped)
    else $error("error or end of medium did not stop the deframer");

  a_silent_when_stopped: assert property (@(posedge clk) disable iff (rst)
    status.stopped |-> !res.valid)
    else $error("result produced after stop");

  a_last_only_data: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last) |-> (res.kind == tird_pkg::EV_DATA))
    else $error("last flag on a non-data event");

endmodule
